// ----- rtl/nms_pkg.sv -----
// ============================================================================
// nms_pkg
// Shared types, constants and the direction binning function for the
// non-maximum suppression block.
// ============================================================================
package nms_pkg;

    localparam int MAG_W = 15;
    localparam int DIR_W = 13;
    localparam int CFG_W = 11;

    localparam int unsigned FULL_TURN   = 5760;  // 360 degrees in 1/16 degree
    localparam int unsigned HALF_SECTOR = 360;   // 22.5 degrees
    localparam int unsigned SECTOR      = 720;   // 45 degrees
    localparam int          NUM_BINS    = 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // Result queue depth.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Suppression axis.
    typedef enum logic [1:0] {
        AXIS_HORIZONTAL = 2'd0,
        AXIS_RISING     = 2'd1,
        AXIS_VERTICAL   = 2'd2,
        AXIS_FALLING    = 2'd3
    } axis_t;

    // One line buffer entry: magnitude two rows back, one row back, and the
    // axis of the pixel one row back.
    typedef struct packed {
        logic [MAG_W-1:0] upper;
        logic [MAG_W-1:0] middle;
        axis_t            sector;
    } line_entry_t;

    // Position flags for the pixel at the window center.
    typedef struct packed {
        logic emit;
        logic last;
        logic left_ok;
        logic right_ok;
        logic up_ok;
        logic down_ok;
    } pos_flags_t;

    typedef struct packed {
        logic [MAG_W-1:0] kept_magnitude;
        logic             frame_last;
    } out_item_t;

    // Sectors are centered on multiples of 45 degrees, lower bound inclusive.
    function automatic axis_t axis_of(input logic [DIR_W-1:0] dir);
        logic [DIR_W-1:0] d;
        logic [3:0]       bin;
        d   = (dir >= DIR_W'(FULL_TURN)) ? dir - DIR_W'(FULL_TURN) : dir;
        bin = '0;
        for (int j = 0; j < NUM_BINS; j++) begin
            if (d >= DIR_W'(HALF_SECTOR + SECTOR * j)) begin
                bin = bin + 4'd1;
            end
        end
        return axis_t'(bin[1:0]);
    endfunction

endpackage

// ----- rtl/nms_ctrl.sv -----
// ============================================================================
// nms_ctrl
// Configuration registers, raster position counters and the issue stage
// that reads the line buffer and tags each pixel with its position flags.
// ============================================================================
module nms_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_W      = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  nms_pkg::cfg_index_t        cfg_index,
    input  logic [nms_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       s_fire,
    input  logic [nms_pkg::MAG_W-1:0]  s_grad_magnitude,
    input  logic [nms_pkg::DIR_W-1:0]  s_grad_direction,
    input  logic                       s_is_padding,
    output logic                       rd_en,
    output logic [COL_W-1:0]           rd_addr,
    output logic                       s1_valid,
    output logic [COL_W-1:0]           s1_addr,
    output logic [nms_pkg::MAG_W-1:0]  s1_mag,
    output nms_pkg::axis_t             s1_sec,
    output nms_pkg::pos_flags_t        s1_flags
);
    import nms_pkg::*;

    localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    axis_t            s1_sec_reg;
    pos_flags_t       s1_flags_reg, flags;

    logic [WSZ_W-1:0] w_size, col_ext, col_plus;
    logic [HSZ_W-1:0] h_size;
    logic [ROW_W-1:0] h_row, h_plus1, r_eff;
    logic [COL_W-1:0] c_eff;
    logic             restart, c_zero, ignore, wrap;

    always_comb begin
        w_size = (width_reg == '0) ? WSZ_W'(1) :
                 (int'(width_reg) > MAX_WIDTH) ? WSZ_W'(MAX_WIDTH) : WSZ_W'(width_reg);
        h_size = (height_reg == '0) ? HSZ_W'(1) :
                 (int'(height_reg) > MAX_HEIGHT) ? HSZ_W'(MAX_HEIGHT) : HSZ_W'(height_reg);
        h_row   = ROW_W'(h_size);
        h_plus1 = h_row + ROW_W'(1);

        // A size change can leave the position outside the frame.
        restart = (WSZ_W'(col_reg) >= w_size) || (row_reg > h_plus1);
        c_eff   = restart ? '0 : col_reg;
        r_eff   = restart ? '0 : row_reg;
        col_ext = WSZ_W'(c_eff);
        c_zero  = (c_eff == '0);
        ignore  = s_is_padding && c_zero && (r_eff == '0);

        // With the center one row and one pixel behind the input, column zero
        // means the center is the last pixel of the row two rows up.
        flags.last     = c_zero && (r_eff == h_plus1);
        flags.emit     = c_zero ? (r_eff >= ROW_W'(2) && r_eff <= h_plus1)
                                : (r_eff >= ROW_W'(1) && r_eff <= h_row);
        flags.left_ok  = c_zero ? (w_size >= WSZ_W'(2)) : (col_ext >= WSZ_W'(2));
        flags.right_ok = !c_zero;
        flags.up_ok    = c_zero ? (r_eff >= ROW_W'(3)) : (r_eff >= ROW_W'(2));
        flags.down_ok  = c_zero ? (r_eff <= h_row) : (r_eff < h_row);

        col_plus = col_ext + WSZ_W'(1);
        wrap     = (col_plus >= w_size);
        if (ignore) begin
            col_next = c_eff;
            row_next = r_eff;
        end else if (flags.last) begin
            col_next = '0;
            row_next = '0;
        end else if (wrap) begin
            col_next = '0;
            row_next = r_eff + ROW_W'(1);
        end else begin
            col_next = COL_W'(col_plus);
            row_next = r_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= s_fire && !ignore;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_addr_reg  <= c_eff;
            s1_mag_reg   <= s_is_padding ? '0 : s_grad_magnitude;
            s1_sec_reg   <= s_is_padding ? AXIS_HORIZONTAL : axis_of(s_grad_direction);
            s1_flags_reg <= flags;
        end
    end

    assign rd_en    = s_fire && !ignore;
    assign rd_addr  = c_eff;
    assign s1_valid = s1_valid_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_mag   = s1_mag_reg;
    assign s1_sec   = s1_sec_reg;
    assign s1_flags = s1_flags_reg;

endmodule

// ----- rtl/nms_line_buf.sv -----
// ============================================================================
// nms_line_buf
// Line buffer memory holding both previous rows and the row-above axis,
// with forwarding for a read of the entry written in the same cycle.
// ============================================================================
module nms_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [COL_W-1:0]     rd_addr,
    input  logic                 wr_en,
    input  logic [COL_W-1:0]     wr_addr,
    input  nms_pkg::line_entry_t wr_data,
    output nms_pkg::line_entry_t rd_data
);
    import nms_pkg::*;

    line_entry_t line_mem_reg [MAX_WIDTH];
    line_entry_t rd_data_reg, fwd_data_reg;
    logic        fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= line_mem_reg[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // The memory returns the old entry when read and write meet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ----- rtl/nms_window.sv -----
// ============================================================================
// nms_window
// 3x3 magnitude window, write-back data for the line buffer, and the
// neighbor compare that decides whether the center is kept.
// ============================================================================
module nms_window (
    input  logic                      aclk,
    input  logic                      s1_valid,
    input  logic [nms_pkg::MAG_W-1:0] s1_mag,
    input  nms_pkg::axis_t            s1_sec,
    input  nms_pkg::pos_flags_t       s1_flags,
    input  nms_pkg::line_entry_t      rd_data,
    output nms_pkg::line_entry_t      wr_data,
    output logic                      push,
    output nms_pkg::out_item_t        push_data
);
    import nms_pkg::*;

    // Row 0 is two rows back, row 2 the current row; column 2 is the newest.
    logic [MAG_W-1:0] win_reg  [3][3];
    logic [MAG_W-1:0] win_next [3][3];
    axis_t            sec_prev_reg;
    logic [MAG_W-1:0] center, n1, n2;
    logic             n1_ok, n2_ok;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = rd_data.upper;
        win_next[1][2] = rd_data.middle;
        win_next[2][2] = s1_mag;

        wr_data.upper  = rd_data.middle;
        wr_data.middle = s1_mag;
        wr_data.sector = s1_sec;

        center = win_next[1][1];
        case (sec_prev_reg)
            AXIS_HORIZONTAL: begin
                n1 = win_next[1][2];  n1_ok = s1_flags.right_ok;
                n2 = win_next[1][0];  n2_ok = s1_flags.left_ok;
            end
            AXIS_RISING: begin
                n1 = win_next[2][2];  n1_ok = s1_flags.down_ok && s1_flags.right_ok;
                n2 = win_next[0][0];  n2_ok = s1_flags.up_ok && s1_flags.left_ok;
            end
            AXIS_VERTICAL: begin
                n1 = win_next[2][1];  n1_ok = s1_flags.down_ok;
                n2 = win_next[0][1];  n2_ok = s1_flags.up_ok;
            end
            AXIS_FALLING: begin
                n1 = win_next[2][0];  n1_ok = s1_flags.down_ok && s1_flags.left_ok;
                n2 = win_next[0][2];  n2_ok = s1_flags.up_ok && s1_flags.right_ok;
            end
        endcase

        // Neighbors outside the frame count as zero; ties keep the center.
        push_data.kept_magnitude = ((n1_ok && center < n1) || (n2_ok && center < n2))
                                 ? '0 : center;
        push_data.frame_last     = s1_flags.last;
        push = s1_valid && s1_flags.emit;
    end

    always_ff @(posedge aclk) begin
        if (s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= win_next[i][j];
                end
            end
            sec_prev_reg <= rd_data.sector;
        end
    end

endmodule

// ----- rtl/nms_out_fifo.sv -----
// ============================================================================
// nms_out_fifo
// Small result queue that decouples the pixel pipeline from the output.
// ============================================================================
module nms_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  nms_pkg::out_item_t            push_data,
    input  logic                          pop,
    output logic                          not_empty,
    output nms_pkg::out_item_t            head,
    output logic [nms_pkg::OUT_CNT_W-1:0] count
);
    import nms_pkg::*;

    out_item_t            fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + OUT_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = fifo_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ----- rtl/canny_non_maximum_suppression_top.sv -----
// ============================================================================
// canny_non_maximum_suppression_top
// Non-maximum suppression over a raster stream of gradient pixels.
// ============================================================================
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    grad_magnitude, grad_direction, is_padding
//   m_       out        m_valid/m_ready    kept_magnitude, frame_last
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wdata (no wait, no read-back)
//
// One input beat is taken per cycle while s_ready is high; the line buffer
// does one read and one write-back per cycle, which sets that rate.
// Pixel k's result comes from input beat k + W + 1 through the result
// queue; W is the clamped frame width and W + 1 padding beats flush a frame.
// Reset is synchronous and active low; the line buffer is not cleared, so no
// clearing pass is needed and the block is ready on the cycle after reset.
// A four-entry result queue absorbs output stalls; s_ready drops only when
// the queue and the pixel in flight could fill it.
//
module canny_non_maximum_suppression_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  nms_pkg::cfg_index_t        cfg_index,
    input  logic [nms_pkg::CFG_W-1:0]  cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nms_pkg::MAG_W-1:0]  s_grad_magnitude,
    input  logic [nms_pkg::DIR_W-1:0]  s_grad_direction,
    input  logic                       s_is_padding,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [nms_pkg::MAG_W-1:0]  m_kept_magnitude,
    output logic                       m_frame_last
);
    import nms_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                 s_fire, rd_en, s1_valid, push, pop;
    logic [COL_W-1:0]     rd_addr, s1_addr;
    logic [MAG_W-1:0]     s1_mag;
    axis_t                s1_sec;
    pos_flags_t           s1_flags;
    line_entry_t          rd_data, wr_data;
    out_item_t            push_data, head;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic [OUT_CNT_W:0]   committed;

    // A beat is taken only when the queue has room for every result that can
    // still arrive: the pixel in the window stage and the one accepted now.
    assign committed = {1'b0, fifo_count} + (OUT_CNT_W + 1)'(s1_valid);
    assign s_ready   = (committed < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign s_fire    = s_valid && s_ready;
    assign pop       = m_valid && m_ready;

    // Position tracking and line buffer read issue.
    nms_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_fire           (s_fire),
        .s_grad_magnitude (s_grad_magnitude),
        .s_grad_direction (s_grad_direction),
        .s_is_padding     (s_is_padding),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .s1_valid         (s1_valid),
        .s1_addr          (s1_addr),
        .s1_mag           (s1_mag),
        .s1_sec           (s1_sec),
        .s1_flags         (s1_flags)
    );

    // The window stage writes each entry back at the column it read, in the
    // cycle after the read; the buffer forwards when the next read hits it.
    nms_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (s1_valid),
        .wr_addr (s1_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    nms_window u_window (
        .aclk      (aclk),
        .s1_valid  (s1_valid),
        .s1_mag    (s1_mag),
        .s1_sec    (s1_sec),
        .s1_flags  (s1_flags),
        .rd_data   (rd_data),
        .wr_data   (wr_data),
        .push      (push),
        .push_data (push_data)
    );

    nms_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (m_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_kept_magnitude = head.kept_magnitude;
    assign m_frame_last     = head.frame_last;

endmodule

// ----- rtl/nms_checker.sv -----
// ============================================================================
// nms_checker
// Port-level checks for the non-maximum suppression block.
// ============================================================================
module nms_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [nms_pkg::MAG_W-1:0] m_kept_magnitude,
    input logic                      m_frame_last
);
    import nms_pkg::*;

    // Input beats taken minus result beats delivered.
    logic [31:0] pending_reg, pending_next;

    always_comb begin
        pending_next = pending_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            pending_next = pending_reg + 32'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            pending_next = pending_reg - 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Reset empties the result queue.
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat offered right after reset");

    // No result can appear without an input beat behind it.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 32'd0))
        else $error("result beat without a pending input beat");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_kept_magnitude) && $stable(m_frame_last)))
        else $error("stalled result beat changed");

endmodule

bind canny_non_maximum_suppression_top nms_checker u_nms_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_kept_magnitude (m_kept_magnitude),
    .m_frame_last     (m_frame_last)
);

// ----- bench/canny_non_maximum_suppression_top_test.sv -----
// ============================================================================
// canny_non_maximum_suppression_top_test
// Self-checking bench for the non-maximum suppression block. Gradient pixel
// beats are driven in raster order under random idling on both channels, and
// every result beat is compared field by field with a typed result or with a
// behavioral window model kept in step with each accepted input beat.
// ============================================================================
module canny_non_maximum_suppression_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nms_pkg::*;

    localparam int LINE_DEPTH   = 1024;       // widest frame the block handles
    localparam int MAX_ROWS     = 1024;       // tallest frame the block handles
    localparam int SETTLE_ABOUT = 8;          // cycles past the last result
    localparam int SMALL_BEATS  = 300;        // beats in the small-frame part
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    typedef enum logic [0:0] {
        ROW_WRITE = 1'b0,
        ROW_BEAT  = 1'b1
    } row_kind_t;

    // One line of the directed stimulus. Beats whose result can be read off
    // directly carry it in typed_result; all others go through the model.
    typedef struct {
        row_kind_t        kind;
        cfg_index_t       index;
        logic [CFG_W-1:0] value;
        logic [MAG_W-1:0] mag;
        logic [DIR_W-1:0] dir;
        logic             pad;
        bit               typed;
        out_item_t        typed_result;
    } stim_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    cfg_index_t       cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [MAG_W-1:0] s_grad_magnitude = '0;
    logic [DIR_W-1:0] s_grad_direction = '0;
    logic             s_is_padding = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [MAG_W-1:0] m_kept_magnitude;
    logic             m_frame_last;

    // When set, neither side idles: this gives one long back-to-back stretch.
    bit steady = 1'b0;
    int error_count = 0;
    int stepped_beats = 0;

    // Shadow of the size registers and of the block's pipeline state.
    logic [CFG_W-1:0] width_reg = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    int               frame_cols = 640;
    int               frame_rows = 480;
    logic [MAG_W-1:0] upper_line  [LINE_DEPTH];
    logic [MAG_W-1:0] middle_line [LINE_DEPTH];
    axis_t            axis_line   [LINE_DEPTH];
    logic [MAG_W-1:0] win [3][3];
    axis_t            axis_pipe [2];
    int               pos_col = 0;
    int               pos_row = 0;

    out_item_t pending_kept [$];
    stim_row_t directed [$];

    canny_non_maximum_suppression_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_grad_magnitude (s_grad_magnitude),
        .s_grad_direction (s_grad_direction),
        .s_is_padding     (s_is_padding),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kept_magnitude (m_kept_magnitude),
        .m_frame_last     (m_frame_last)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case a handshake hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("** canny_non_maximum_suppression_top: FAILED **");
        $finish;
    end

    // A size register value of zero means one, and anything past the
    // supported maximum is held at the maximum.
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v == '0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Directions are binned into 45 degree sectors centered on multiples of
    // 45 degrees; opposite sectors share an axis. Values past a full turn
    // wrap once.
    function automatic axis_t direction_axis(input logic [DIR_W-1:0] dir);
        int unsigned d;
        d = dir;
        if (d >= FULL_TURN) d -= FULL_TURN;
        return axis_t'(2'((d + HALF_SECTOR) / SECTOR));
    endfunction

    // Neighbor of the window center, or zero when it falls outside the frame.
    function automatic logic [MAG_W-1:0] window_tap(input int cx, cy, dx, dy);
        if (cx + dx < 0 || cx + dx >= frame_cols) return '0;
        if (cy + dy < 0 || cy + dy >= frame_rows) return '0;
        return win[1 + dy][1 + dx];
    endfunction

    // Advances the window model by one accepted beat. The center of the
    // window trails the input by one row and one pixel, so a result comes
    // out once the frame is that far along.
    function automatic void nms_step(input logic [MAG_W-1:0] mag,
                                     input logic [DIR_W-1:0] dir,
                                     input logic pad,
                                     output bit produced,
                                     output out_item_t result);
        logic [MAG_W-1:0] pix;
        logic [MAG_W-1:0] center;
        logic [MAG_W-1:0] n1;
        logic [MAG_W-1:0] n2;
        axis_t            ax;
        int               c;
        int               r;
        int               cx;
        int               cy;
        int               dx;
        int               dy;
        bit               is_last;
        produced = 1'b0;
        result = '0;

        // A size change that leaves the position outside the frame restarts it.
        if (pos_col >= frame_cols || pos_row > frame_rows + 1) begin
            pos_col = 0;
            pos_row = 0;
        end
        // Flush beats that arrive with no frame under way are dropped.
        if (pad && pos_row == 0 && pos_col == 0) return;
        stepped_beats++;

        pix = pad ? '0 : mag;
        ax  = pad ? AXIS_HORIZONTAL : direction_axis(dir);
        c = pos_col;
        r = pos_row;

        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = pix;
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;
        axis_pipe[0] = axis_pipe[1];
        axis_pipe[1] = axis_line[c];
        axis_line[c] = ax;

        if (c == 0) begin
            cx = frame_cols - 1;
            cy = r - 2;
        end else begin
            cx = c - 1;
            cy = r - 1;
        end

        pos_col = c + 1;
        if (pos_col >= frame_cols) begin
            pos_col = 0;
            pos_row = r + 1;
        end

        if (cy < 0 || cy >= frame_rows) return;

        // One neighbor is (dx, dy) from the center, the other its mirror.
        case (axis_pipe[0])
            AXIS_HORIZONTAL: begin dx = 1;  dy = 0; end
            AXIS_RISING:     begin dx = 1;  dy = 1; end
            AXIS_VERTICAL:   begin dx = 0;  dy = 1; end
            default:         begin dx = -1; dy = 1; end
        endcase
        center = win[1][1];
        n1 = window_tap(cx, cy, dx, dy);
        n2 = window_tap(cx, cy, -dx, -dy);

        is_last = (cy == frame_rows - 1) && (cx == frame_cols - 1);
        if (is_last) begin
            pos_col = 0;
            pos_row = 0;
        end

        // Ties keep the pixel; only a strictly larger neighbor suppresses it.
        produced = 1'b1;
        result.kept_magnitude = (center < n1 || center < n2) ? '0 : center;
        result.frame_last = is_last;
    endfunction

    // Magnitudes are mostly uniform over the full range; some come from 0..3 so
    // that ties are common, and the full-scale extremes are mixed in.
    function automatic logic [MAG_W-1:0] rand_mag();
        case ($urandom_range(7))
            0:       return MAG_W'($urandom_range(3));
            1:       return $urandom_range(1) ? {MAG_W{1'b1}} : '0;
            default: return MAG_W'($urandom);
        endcase
    endfunction

    // Directions mostly span one turn, some sit on either side of a sector
    // bound, and some use the whole field so that wrapped values show up.
    function automatic logic [DIR_W-1:0] rand_dir();
        int k;
        k = $urandom_range(NUM_BINS - 1);
        case ($urandom_range(7))
            0:       return DIR_W'($urandom);
            1:       return DIR_W'(HALF_SECTOR + SECTOR * k) - DIR_W'($urandom_range(1));
            default: return DIR_W'($urandom_range(FULL_TURN - 1));
        endcase
    endfunction

    function automatic stim_row_t write_row(input cfg_index_t idx,
                                            input logic [CFG_W-1:0] value);
        stim_row_t row;
        row = '{kind: ROW_WRITE, index: idx, value: value, mag: '0, dir: '0,
                pad: 1'b0, typed: 1'b0, typed_result: '0};
        return row;
    endfunction

    function automatic stim_row_t beat_row(input logic [MAG_W-1:0] mag,
                                           input logic [DIR_W-1:0] dir,
                                           input logic pad,
                                           input bit typed = 1'b0,
                                           input logic [MAG_W-1:0] kept = '0,
                                           input logic is_last = 1'b0);
        stim_row_t row;
        row = '{kind: ROW_BEAT, index: REG_FRAME_WIDTH, value: '0, mag: mag,
                dir: dir, pad: pad, typed: typed, typed_result: '0};
        row.typed_result.kept_magnitude = kept;
        row.typed_result.frame_last = is_last;
        return row;
    endfunction

    // Drives one input beat from the falling edge, holds it until the block
    // takes it, then steps the model and records what the block owes us.
    task automatic send_beat(input logic [MAG_W-1:0] mag,
                             input logic [DIR_W-1:0] dir,
                             input logic pad,
                             input bit typed = 1'b0,
                             input out_item_t typed_result = '0);
        bit        produced;
        out_item_t result;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_grad_magnitude <= mag;
        s_grad_direction <= dir;
        s_is_padding     <= pad;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        nms_step(mag, dir, pad, produced, result);
        if (typed) begin
            pending_kept.push_back(typed_result);
        end else if (produced) begin
            pending_kept.push_back(result);
        end
    endtask

    // Drops valid and waits until every owed result has come back, plus a
    // settling wait for beats still in the pipe that produce nothing.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_kept.size() != 0) @(negedge aclk);
        repeat (SETTLE_ABOUT) @(negedge aclk);
    endtask

    // Only called with the block idle.
    task automatic set_register(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = value;
        end else begin
            height_reg = value;
        end
        frame_cols = clamp_dim(width_reg, LINE_DEPTH);
        frame_rows = clamp_dim(height_reg, MAX_ROWS);
    endtask

    // One full frame with random content, followed by the flush beats. A few
    // stray flush beats may lead the frame; the block ignores them. The flush
    // itself mixes padding with real pixels past the frame end.
    task automatic send_frame();
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) send_beat(rand_mag(), rand_dir(), 1'b1);
        end
        repeat (frame_cols * frame_rows) begin
            send_beat(rand_mag(), rand_dir(), $urandom_range(19) == 0);
        end
        repeat (frame_cols + 1) begin
            send_beat(rand_mag(), rand_dir(), $urandom_range(3) != 0);
        end
    endtask

    // Sets both size registers, optionally breaks off one frame partway and
    // shrinks the size so that the block has to restart, then sends frames.
    task automatic run_phase(input logic [CFG_W-1:0] cols,
                             input logic [CFG_W-1:0] rows,
                             input int frames,
                             input bit allow_cut);
        drain_results();
        set_register(REG_FRAME_WIDTH, cols);
        set_register(REG_FRAME_HEIGHT, rows);
        if (allow_cut && frame_cols >= 2 && $urandom_range(4) == 0) begin
            repeat ($urandom_range(1, frame_cols * frame_rows - 1)) begin
                send_beat(rand_mag(), rand_dir(), 1'b0);
            end
            if (pos_col == 0) send_beat(rand_mag(), rand_dir(), 1'b0);
            drain_results();
            // Only shrink: the new size must push the position out of the
            // frame, so no line buffer entry is read before this frame writes it.
            if (pos_row >= 3 && $urandom_range(1) == 1) begin
                set_register(REG_FRAME_HEIGHT, CFG_W'($urandom_range(1, pos_row - 2)));
            end else begin
                set_register(REG_FRAME_WIDTH, CFG_W'($urandom_range(1, pos_col)));
            end
        end
        repeat (frames) send_frame();
    endtask

    // Output side: random back-pressure, sampled by the block at the next
    // rising edge.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 34);
    end

    // Every result beat must match the oldest owed result, field by field.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_kept.size() == 0) begin
                error_count++;
                $display("%0t: result beat with none expected: kept_magnitude %0d, frame_last %0b",
                         $time, m_kept_magnitude, m_frame_last);
            end else begin
                want = pending_kept.pop_front();
                if (m_kept_magnitude !== want.kept_magnitude) begin
                    error_count++;
                    $display("%0t: kept_magnitude expected %0d, actual %0d",
                             $time, want.kept_magnitude, m_kept_magnitude);
                end
                if (m_frame_last !== want.frame_last) begin
                    error_count++;
                    $display("%0t: frame_last expected %0b, actual %0b",
                             $time, want.frame_last, m_frame_last);
                end
            end
        end
    end

    initial begin
        int start_beats;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;

        foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
            axis_line[i]   = AXIS_HORIZONTAL;
        end
        foreach (win[i, j]) win[i][j] = '0;
        axis_pipe[0] = AXIS_HORIZONTAL;
        axis_pipe[1] = AXIS_HORIZONTAL;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Out of reset the frame is 640 pixels wide, so the first result
        // shows up only after a row and one pixel. A leading flush beat is
        // ignored. The frame is left unfinished on purpose: the width write
        // that follows forces a restart.
        send_beat(rand_mag(), rand_dir(), 1'b1);
        repeat (645) send_beat(rand_mag(), rand_dir(), 1'b0);

        // Directed part. A zero size clamps to a single pixel, which has no
        // neighbor inside the frame and so is always kept; its result comes
        // two beats later with frame_last set. Pixels sent in place of
        // padding after the frame end must not disturb it.
        directed.push_back(write_row(REG_FRAME_WIDTH, 11'd0));
        directed.push_back(write_row(REG_FRAME_HEIGHT, 11'd0));
        directed.push_back(beat_row(15'd0, 13'd0, 1'b1));
        directed.push_back(beat_row(15'h7FFF, 13'd0, 1'b0));
        directed.push_back(beat_row(15'd0, 13'd0, 1'b1));
        directed.push_back(beat_row(15'd0, 13'd0, 1'b1, 1'b1, 15'h7FFF, 1'b1));
        directed.push_back(beat_row(15'd0, 13'h1FFF, 1'b0));
        directed.push_back(beat_row(15'd21845, 13'd5759, 1'b0));
        directed.push_back(beat_row(15'd0, 13'd0, 1'b1, 1'b1, 15'd0, 1'b1));
        directed.push_back(beat_row(15'd10922, 13'd5760, 1'b0));
        directed.push_back(beat_row(15'd0, 13'd0, 1'b1));
        directed.push_back(beat_row(15'd12345, 13'd720, 1'b0, 1'b1, 15'd10922, 1'b1));
        // A 3x2 frame that uses every axis, both sides of a sector bound and
        // equal neighbors; checked against the model.
        directed.push_back(write_row(REG_FRAME_WIDTH, 11'd3));
        directed.push_back(write_row(REG_FRAME_HEIGHT, 11'd2));
        directed.push_back(beat_row(15'd100, 13'd0, 1'b0));
        directed.push_back(beat_row(15'd100, 13'd720, 1'b0));
        directed.push_back(beat_row(15'd50, 13'd1440, 1'b0));
        directed.push_back(beat_row(15'd200, 13'd2160, 1'b0));
        directed.push_back(beat_row(15'd100, 13'd359, 1'b0));
        directed.push_back(beat_row(15'd300, 13'd360, 1'b0));
        repeat (4) directed.push_back(beat_row(15'd0, 13'd0, 1'b1));

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE) begin
                drain_results();
                set_register(directed[i].index, directed[i].value);
            end else begin
                send_beat(directed[i].mag, directed[i].dir, directed[i].pad,
                          directed[i].typed, directed[i].typed_result);
            end
        end

        // Largest sizes, reached through out-of-range writes that clamp. A
        // full-width row and a few pixels of the next run without any idling
        // on either side; the frame is then broken off by the width write of
        // the tall single-column frame that follows.
        drain_results();
        steady = 1'b1;
        set_register(REG_FRAME_WIDTH, 11'd2047);
        set_register(REG_FRAME_HEIGHT, 11'd2047);
        repeat (LINE_DEPTH + 8) send_beat(rand_mag(), rand_dir(), 1'b0);
        drain_results();
        steady = 1'b0;
        run_phase(11'd1, 11'd2047, 1, 1'b0);

        // Small frames of random size, now and then with a zero size or a
        // frame broken off by a size change.
        start_beats = stepped_beats;
        while (stepped_beats - start_beats < SMALL_BEATS) begin
            if ($urandom_range(9) == 0) begin
                cols = '0;
            end else if ($urandom_range(7) == 0) begin
                cols = CFG_W'($urandom_range(13, 40));
            end else begin
                cols = CFG_W'($urandom_range(1, 12));
            end
            rows = ($urandom_range(9) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
            run_phase(cols, rows, $urandom_range(1, 3), 1'b1);
        end

        drain_results();
        if (error_count == 0) begin
            $display("** canny_non_maximum_suppression_top: PASSED **");
        end else begin
            $display("** canny_non_maximum_suppression_top: FAILED **");
        end
        $finish;
    end

endmodule
